FILE: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round robin task scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = 32;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_WAITING = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_SLEEP  = 3'd1,
        REQ_EXIT   = 3'd2,
        REQ_CREATE = 3'd3,
        REQ_ALARM  = 3'd4
    } req_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
    localparam logic [1:0] STATUS_SHUTDOWN = 2'd2;

    // one table entry: state plus sleep countdown
    typedef struct packed {
        slot_state_t    st;
        logic [CNT_W-1:0] sleep;
    } entry_t;

    // port of the slot table
    typedef struct packed {
        logic   rd_en;
        slot_t  rd_addr;
        logic   wr_en;
        slot_t  wr_addr;
        entry_t wr_data;
    } mem_req_t;

endpackage

FILE: rtl/core/rrts_slot_ram.sv
// ----------------------------------------------------------------------------
// rrts_slot_ram
// Slot table: one write and one registered read port, with no reset of its own.
// ----------------------------------------------------------------------------
module rrts_slot_ram (
    input  logic              clk,
    input  rrts_pkg::mem_req_t mreq,
    output rrts_pkg::entry_t   rd_data
);
    import rrts_pkg::*;

    entry_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        if (mreq.rd_en)
        begin
            rd_data <= mem[mreq.rd_addr];
        end
    end

endmodule

FILE: rtl/core/round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round robin scheduler with per-slot sleep timers and one periodic alarm.
// ----------------------------------------------------------------------------
// Each request runs sequentially over the slot table, held in a synchronous
// RAM with one write port and one registered read port. After reset a clearing
// pass writes every slot before the first request is taken.
// A tick walks every slot once to count down sleepers, then walks again for
// the round robin pick; sleep and exit also walk twice (update, then pick).
// Each walk reads one table entry a cycle through the table port; after the
// pick the chosen slot is marked running (read, then rewrite), and the finish
// and output states load the result. A new request is taken only once the
// result has been loaded and the scheduler is back in idle. Create walks once,
// an exit that shuts down walks once and marks slot 0, and set alarm and
// unknown codes skip the table and pass straight through finish and output.
// The result is held in an output register so the next request may be taken
// while it waits; a result not yet taken stalls only the following result.
module round_robin_task_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] req_type, [34:3] tick_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [3:0] running_slot, [4] switched,
                                   // [5] alarm_fired, [37:6] ret_value,
                                   // [39:38] status
);
    import rrts_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } fsm_t;

    localparam int IDX_W = SLOT_W + 1;

    fsm_t             state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;       // address issued
    logic             rv_reg, rv_next;          // read data valid
    slot_t            ra_reg, ra_next;          // address of read data
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] ticks_reg, ticks_next;
    slot_t            run_reg, run_next, before_reg, before_next;
    logic [CNT_W-1:0] alarm_left_reg, alarm_left_next;
    logic [CNT_W-1:0] period_reg, period_next;
    logic             fired_reg, fired_next;
    logic [CNT_W-1:0] ret_reg, ret_next;
    logic [1:0]       status_reg, status_next;
    logic             found_reg, found_next, any_reg, any_next;
    slot_t            pick_reg, pick_next;
    logic             cur_ready_reg, cur_ready_next;
    logic             ov_reg, ov_next;
    logic [39:0]      od_reg, od_next;

    mem_req_t mreq;
    entry_t   rd;
    entry_t   upd;
    slot_t    ia;
    slot_t    scan_addr;

    rrts_slot_ram u_ram (
        .clk     (clk),
        .mreq    (mreq),
        .rd_data (rd)
    );

    assign ia        = idx_reg[SLOT_W-1:0];
    assign scan_addr = slot_t'(before_reg + ia + slot_t'(1));  // pick order
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = od_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rv_next        = 1'b0;
        ra_next        = ra_reg;
        req_next       = req_reg;
        ticks_next     = ticks_reg;
        run_next       = run_reg;
        before_next    = before_reg;
        alarm_left_next = alarm_left_reg;
        period_next    = period_reg;
        fired_next     = fired_reg;
        ret_next       = ret_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        any_next       = any_reg;
        pick_next      = pick_reg;
        cur_ready_next = cur_ready_reg;
        ov_next        = ov_reg && !m_tready;
        od_next        = od_reg;
        mreq           = '0;
        upd            = rd;

        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = ia;
                mreq.wr_data.st    = (ia == '0) ? ST_RUNNING : ST_UNUSED;
                mreq.wr_data.sleep = '0;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    req_next    = req_t'(s_tdata[2:0]);
                    ticks_next  = s_tdata[34:3];
                    before_next = run_reg;
                    fired_next  = 1'b0;
                    ret_next    = '0;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    any_next    = 1'b0;
                    idx_next    = '0;
                    unique case (s_tdata[2:0])
                        REQ_TICK, REQ_SLEEP, REQ_EXIT, REQ_CREATE:
                        begin
                            state_next = S_SCAN;
                            status_next = (s_tdata[2:0] == REQ_CREATE) ?
                                          STATUS_NO_SLOT : STATUS_OK;
                        end
                        REQ_ALARM:
                        begin
                            ret_next        = alarm_left_reg;
                            alarm_left_next = s_tdata[34:3];
                            period_next     = s_tdata[34:3];
                            state_next      = S_FIN;
                        end
                        default: state_next = S_FIN;
                    endcase
                    if (s_tdata[2:0] == REQ_TICK && alarm_left_reg != '0)
                    begin
                        if (alarm_left_reg == CNT_W'(1))
                        begin
                            fired_next      = 1'b1;
                            alarm_left_next = period_reg;
                        end
                        else
                        begin
                            alarm_left_next = alarm_left_reg - CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // read slot idx, modify and write it back in the following cycle
                if (idx_reg != IDX_W'(NUM_SLOTS))
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = ia;
                    ra_next      = ia;
                    rv_next      = 1'b1;
                    idx_next     = idx_reg + IDX_W'(1);
                end
                if (rv_reg)
                begin
                    mreq.wr_addr = ra_reg;
                    unique case (req_reg)
                        REQ_TICK:
                        begin
                            if (ra_reg != '0 && rd.st == ST_WAITING && rd.sleep != '0)
                            begin
                                if (rd.sleep == CNT_W'(1))
                                begin
                                    upd.st = ST_READY;
                                end
                                upd.sleep = rd.sleep - CNT_W'(1);
                            end
                            if (ra_reg == before_reg && rd.st == ST_RUNNING)
                            begin
                                upd.st = ST_READY;
                            end
                            mreq.wr_en = 1'b1;
                        end
                        REQ_SLEEP:
                        begin
                            if (ra_reg == before_reg)
                            begin
                                upd.st     = ST_WAITING;
                                upd.sleep  = ticks_reg;
                                mreq.wr_en = 1'b1;
                            end
                        end
                        REQ_EXIT:
                        begin
                            if (ra_reg == before_reg)
                            begin
                                upd.st     = ST_UNUSED;
                                mreq.wr_en = 1'b1;
                            end
                            else if (ra_reg != '0 && rd.st != ST_UNUSED)
                            begin
                                any_next = 1'b1;
                            end
                        end
                        REQ_CREATE:
                        begin
                            if (ra_reg != '0 && rd.st == ST_UNUSED && !found_reg)
                            begin
                                upd.st      = ST_READY;
                                upd.sleep   = '0;
                                mreq.wr_en  = 1'b1;
                                found_next  = 1'b1;
                                ret_next    = CNT_W'(ra_reg);
                                status_next = STATUS_OK;
                            end
                        end
                        default: ;
                    endcase
                    mreq.wr_data = upd;
                end
                if (idx_reg == IDX_W'(NUM_SLOTS) && !rv_reg)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (req_reg == REQ_CREATE)
                    begin
                        state_next = S_FIN;
                    end
                    else if (req_reg == REQ_EXIT && !any_reg)
                    begin
                        status_next = STATUS_SHUTDOWN;
                        pick_next   = '0;
                        state_next  = S_MARK;
                    end
                    else
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                // visit slots after the current one in round robin order
                if (idx_reg != IDX_W'(NUM_SLOTS))
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = scan_addr;
                    ra_next      = scan_addr;
                    rv_next      = 1'b1;
                    idx_next     = idx_reg + IDX_W'(1);
                end
                if (rv_reg)
                begin
                    if (ra_reg == before_reg)
                    begin
                        cur_ready_next = (rd.st == ST_READY);
                    end
                    else if (ra_reg != '0 && rd.st == ST_READY && !found_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = ra_reg;
                    end
                end
                if (idx_reg == IDX_W'(NUM_SLOTS) && !rv_reg)
                begin
                    if (!found_reg)
                    begin
                        pick_next = cur_ready_reg ? before_reg : '0;
                    end
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                // running slot keeps its countdown: read, then rewrite state
                if (!rv_reg)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = pick_reg;
                    rv_next      = 1'b1;
                end
                else
                begin
                    upd.st       = ST_RUNNING;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = pick_reg;
                    mreq.wr_data = upd;
                    run_next     = pick_reg;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {status_reg, ret_reg, fired_reg,
                               (run_reg != before_reg), 4'(run_reg)};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            rv_reg         <= 1'b0;
            run_reg        <= '0;
            alarm_left_reg <= '0;
            period_reg     <= '0;
            ov_reg         <= 1'b0;
            found_reg      <= 1'b0;
            any_reg        <= 1'b0;
            cur_ready_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rv_reg         <= rv_next;
            run_reg        <= run_next;
            alarm_left_reg <= alarm_left_next;
            period_reg     <= period_next;
            ov_reg         <= ov_next;
            found_reg      <= found_next;
            any_reg        <= any_next;
            cur_ready_reg  <= cur_ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg     <= ra_next;
        req_reg    <= req_next;
        ticks_reg  <= ticks_next;
        before_reg <= before_next;
        fired_reg  <= fired_next;
        ret_reg    <= ret_next;
        status_reg <= status_next;
        pick_reg   <= pick_next;
        od_reg     <= od_next;
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Round robin task scheduler testbench
// Streams tick, sleep, exit, create and alarm requests into the scheduler,
// predicts each result with a behavioural copy of the slot table and checks
// every response field by field under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rrts_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    round_robin_task_scheduler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // kind sits in the low bits, as on s_tdata
    typedef struct packed {
        logic [31:0] ticks;
        logic [2:0]  kind;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ret_value;
        logic        alarm_fired;
        logic        switched;
        slot_t       running_slot;
    } sched_resp_t;

    // predictor state
    slot_state_t      task_st [NUM_SLOTS];
    logic [CNT_W-1:0] task_sleep [NUM_SLOTS];
    slot_t            cur_slot;
    logic [31:0]      alarm_cnt;
    logic [31:0]      alarm_reload;

    sched_req_t  pending_reqs [$];
    sched_resp_t expected_resps [$];

    int errors;
    int sent;
    int received;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    bit sender_pause;
    bit stim_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (response %0d)", what, got, want,
                 received);
        errors++;
    endtask

    function automatic void sched_reset();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            task_st[i]    = ST_UNUSED;
            task_sleep[i] = '0;
        end
        task_st[0]   = ST_RUNNING;
        cur_slot     = '0;
        alarm_cnt    = '0;
        alarm_reload = '0;
    endfunction

    function automatic void pick_next();
        slot_t nxt;
        slot_t idx;
        bit    found;
        nxt   = '0;
        found = 1'b0;
        for (int j = 1; j < NUM_SLOTS; j++)
        begin
            idx = slot_t'(cur_slot + j);
            if (!found && idx != 0 && task_st[idx] == ST_READY)
            begin
                nxt   = idx;
                found = 1'b1;
            end
        end
        if (!found)
            nxt = (task_st[cur_slot] == ST_READY) ? cur_slot : slot_t'(0);
        task_st[nxt] = ST_RUNNING;
        cur_slot     = nxt;
    endfunction

    function automatic sched_resp_t schedule(input sched_req_t r);
        sched_resp_t o;
        slot_t       prev;
        bit          any_left;
        o    = '0;
        prev = cur_slot;
        case (r.kind)
            REQ_TICK:
            begin
                if (alarm_cnt != 0)
                begin
                    if (alarm_cnt == 1)
                    begin
                        o.alarm_fired = 1'b1;
                        alarm_cnt     = alarm_reload;
                    end
                    else
                        alarm_cnt--;
                end
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (task_st[i] == ST_WAITING && task_sleep[i] != 0)
                    begin
                        if (task_sleep[i] == 1)
                            task_st[i] = ST_READY;
                        task_sleep[i]--;
                    end
                if (task_st[prev] == ST_RUNNING)
                    task_st[prev] = ST_READY;
                pick_next();
            end
            REQ_SLEEP:
            begin
                task_st[prev]    = ST_WAITING;
                task_sleep[prev] = r.ticks;
                pick_next();
            end
            REQ_EXIT:
            begin
                task_st[prev] = ST_UNUSED;
                any_left = 1'b0;
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (task_st[i] != ST_UNUSED)
                        any_left = 1'b1;
                if (any_left)
                    pick_next();
                else
                begin
                    o.status   = STATUS_SHUTDOWN;
                    task_st[0] = ST_RUNNING;
                    cur_slot   = '0;
                end
            end
            REQ_CREATE:
            begin
                o.status = STATUS_NO_SLOT;
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (o.status == STATUS_NO_SLOT && task_st[i] == ST_UNUSED)
                    begin
                        task_st[i]    = ST_READY;
                        task_sleep[i] = '0;
                        o.ret_value   = 32'(i);
                        o.status      = STATUS_OK;
                    end
            end
            REQ_ALARM:
            begin
                o.ret_value  = alarm_cnt;
                alarm_cnt    = r.ticks;
                alarm_reload = r.ticks;
            end
            default: ;
        endcase
        o.running_slot = cur_slot;
        o.switched     = (cur_slot != prev);
        return o;
    endfunction

    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic void push_req(input logic [2:0] k, input logic [31:0] t);
        sched_req_t r;
        r.kind  = k;
        r.ticks = t;
        pending_reqs.push_back(r);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_resps.push_back(schedule(sched_req_t'(s_tdata[34:0])));
                sent++;
            end
            if ((!s_tvalid || s_tready) )
            begin
                if (pending_reqs.size() != 0 && !sender_pause &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, pending_reqs.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        sched_resp_t got;
        sched_resp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = sched_resp_t'(m_tdata);
                if (expected_resps.size() == 0)
                begin
                    report_mismatch("unexpected response", m_tdata[31:0], 32'h0);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (got.running_slot !== want.running_slot)
                        report_mismatch("running_slot", 32'(got.running_slot),
                                        32'(want.running_slot));
                    if (got.switched !== want.switched)
                        report_mismatch("switched", 32'(got.switched), 32'(want.switched));
                    if (got.alarm_fired !== want.alarm_fired)
                        report_mismatch("alarm_fired", 32'(got.alarm_fired),
                                        32'(want.alarm_fired));
                    if (got.ret_value !== want.ret_value)
                        report_mismatch("ret_value", got.ret_value, want.ret_value);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
                received++;
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)      push_req(REQ_TICK, $urandom);
            else if (k < 55) push_req(REQ_SLEEP, rand_ticks());
            else if (k < 67) push_req(REQ_EXIT, $urandom);
            else if (k < 88) push_req(REQ_CREATE, $urandom);
            else if (k < 96) push_req(REQ_ALARM, rand_ticks());
            else             push_req(3'($urandom_range(5, 7)), $urandom);
        end
    endtask

    initial
    begin
        errors = 0; sent = 0; received = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 0; sender_pause = 1'b0; stim_done = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        sched_reset();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, creates until full, extreme counts, unknown codes
        push_req(REQ_TICK, 32'h0);
        push_req(REQ_EXIT, 32'h0);
        push_req(REQ_ALARM, 32'h2);
        push_req(REQ_TICK, 32'hFFFF_FFFF);
        push_req(REQ_TICK, 32'h0);
        for (int i = 0; i < 16; i++)
            push_req(REQ_CREATE, 32'h0);
        push_req(REQ_SLEEP, 32'h0);
        push_req(REQ_SLEEP, 32'hFFFF_FFFF);
        push_req(REQ_ALARM, 32'hFFFF_FFFF);
        push_req(3'd7, 32'hFFFF_FFFF);
        push_req(3'd5, 32'h0);
        wait_drained();

        random_phase(350);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 400;
        random_phase(150);
        wait_drained();

        send_idle_pct = 88;
        random_phase(300);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 88;
        random_phase(300);
        wait_drained();
        send_idle_pct = 21; recv_stall_pct = 21;
        random_phase(200);
        while (pending_reqs.size() > 100)
            @(posedge clk);
        // sender pauses until everything outstanding is back
        sender_pause = 1'b1;
        while (expected_resps.size() != 0 || s_tvalid)
            @(posedge clk);
        sender_pause = 1'b0;
        random_phase(200);
        wait_drained();
        repeat (40) @(posedge clk);

        $display("Ran %0d requests with %0d responses checked over tick, sleep, exit,",
                 sent, received);
        $display("create, alarm and unknown codes under idle, stall and hold-off mixes.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
